[rtl/xcpr_pkg.sv]
// Package for the XMODEM-CRC packet receiver.
// Holds the frame constants, the result and register codes and the sequencer states.
// It has no dependencies.
package xcpr_pkg;

  localparam int unsigned PAYLOAD_BYTES  = 128;
  localparam int unsigned MAX_PACKETS    = 4096;
  localparam int unsigned WORDS          = PAYLOAD_BYTES / 8;
  localparam int unsigned WORD_IDX_W     = $clog2(WORDS);
  localparam int unsigned DATA_FRAME_LEN = PAYLOAD_BYTES + 5;
  localparam int unsigned COUNT_W        = 13;
  localparam int unsigned TOTAL_W        = 20;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  SOH      = 8'h01;
  localparam logic [7:0]  EOT      = 8'h04;

  // Result kinds.
  localparam logic [1:0] RK_WRITE = 2'd0;
  localparam logic [1:0] RK_REPLY = 2'd1;
  localparam logic [1:0] RK_DONE  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEST_EXTERNAL  = 2'd0;
  localparam logic [1:0] CFG_INTERNAL_BASE  = 2'd1;
  localparam logic [1:0] CFG_EXTERNAL_BLOCK = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC,
    S_RD,
    S_WORD,
    S_ACK,
    S_NAK,
    S_EOT_ACK,
    S_DONE
  } state_t;

endpackage

[rtl/xmodem_crc_packet_receiver.sv]
// Top level of the XMODEM-CRC packet receiver: frame tracking, bit-serial CRC,
// payload buffer, flash write drain and ACK/NAK replies.
// Depends on xcpr_pkg.

// A received byte is taken while the sequencer is idle, except that a payload byte
// (frame positions 3 to 130) keeps the input stalled while the single CRC
// shift-and-xor unit steps through its bits. Start items and the other bytes are
// taken without that stall. A good packet then drains its 16 write words from the
// 16 x 64 payload buffer, each by a buffer read and then an output load, followed
// by the ACK, before the input is free again; the end-of-transfer frame yields an
// ACK and then a done result. Results sit in an output register, so a new item is
// taken while the last result still waits for its transfer. No clearing pass is
// needed after reset.
module xmodem_crc_packet_receiver (
  input  logic        clk,
  input  logic        rst,
  // Configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Input items
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        kind,
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  // Results
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  result_kind,
  output logic        reply_nak,
  output logic [31:0] write_address,
  output logic [63:0] write_data,
  output logic [19:0] total_bytes,
  output logic        last
);
  import xcpr_pkg::*;

  localparam logic [7:0] PAY_START = 8'd3;
  localparam logic [7:0] PAY_END   = 8'(PAYLOAD_BYTES + 3);
  localparam logic [7:0] RCV_LO    = 8'(PAYLOAD_BYTES + 4);
  localparam logic [7:0] DATA_LEN  = 8'(DATA_FRAME_LEN);
  localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(WORDS - 1);

  // Configuration registers
  logic        dest_external;
  logic [31:0] internal_base_address;
  logic [6:0]  external_block;

  // Frame and session state
  state_t               state, state_next;
  logic                 session_active;
  logic [7:0]           frame_length;
  logic [7:0]           first_byte;
  logic [15:0]          running_crc;
  logic [15:0]          received_crc;
  logic [COUNT_W-1:0]   packet_count;
  logic [2:0]           bit_cnt;
  logic [63:0]          word_buf;
  logic [WORD_IDX_W-1:0] word_idx;
  logic [31:0]          addr;
  logic [63:0]          rd_data;
  logic [63:0]          pkt_mem [WORDS];

  // Decode of the byte on offer
  logic        item_fire;
  logic        out_free;
  logic        out_load;
  logic        is_byte;
  logic        is_payload;
  logic [7:0]  pay_off;
  logic [7:0]  len_new;
  logic [7:0]  fb;
  logic        crc_ok;
  logic        room;
  logic        is_data;
  logic        is_eot;
  logic        good_pkt;
  logic [31:0] dest_base;

  // Output register next values
  logic [1:0]  rk_next;
  logic        nak_next;
  logic [31:0] addr_next;
  logic [63:0] data_next;
  logic [19:0] total_next;
  logic        last_next;

  assign item_fire  = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;
  assign is_byte    = item_fire && !kind;
  assign is_payload = (frame_length >= PAY_START) && (frame_length < PAY_END);
  assign pay_off    = frame_length - PAY_START;
  assign len_new    = (frame_length == 8'hFF) ? 8'hFF : frame_length + 8'd1;
  assign fb         = (frame_length == 8'd0) ? rx_byte : first_byte;
  // The low CRC byte arrives with the last byte of a data frame itself.
  assign crc_ok     = running_crc == {received_crc[15:8], rx_byte};
  assign room       = packet_count < COUNT_W'(MAX_PACKETS);
  assign is_data    = (len_new == DATA_LEN) && (fb == SOH);
  assign is_eot     = (len_new == 8'd1) && (fb == EOT);
  assign good_pkt   = is_data && crc_ok && room;
  assign dest_base  = dest_external ? {9'd0, external_block, 16'd0} : internal_base_address;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (is_byte) begin
          if (is_payload) begin
            state_next = S_CRC;
          end else if (frame_end && session_active) begin
            if (is_data) begin
              state_next = good_pkt ? S_RD : S_NAK;
            end else if (is_eot) begin
              state_next = S_EOT_ACK;
            end
          end
        end
      end
      S_CRC: begin
        if (bit_cnt == 3'd7) begin
          state_next = S_IDLE;
        end
      end
      S_RD: state_next = S_WORD;
      S_WORD: begin
        if (out_free) begin
          state_next = (word_idx == LAST_WORD) ? S_ACK : S_RD;
        end
      end
      S_ACK, S_NAK, S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_EOT_ACK: begin
        if (out_free) begin
          state_next = S_DONE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    item_ready = 1'b0;
    out_load   = 1'b0;
    rk_next    = RK_REPLY;
    nak_next   = 1'b0;
    addr_next  = 32'd0;
    data_next  = 64'd0;
    total_next = 20'd0;
    last_next  = 1'b0;
    unique case (state)
      S_IDLE: item_ready = 1'b1;
      S_CRC, S_RD: begin
      end
      S_WORD: begin
        out_load  = out_free;
        rk_next   = RK_WRITE;
        addr_next = addr;
        data_next = rd_data;
      end
      S_ACK: begin
        out_load  = out_free;
        last_next = 1'b1;
      end
      S_NAK: begin
        out_load  = out_free;
        nak_next  = 1'b1;
        last_next = 1'b1;
      end
      S_EOT_ACK: out_load = out_free;
      S_DONE: begin
        out_load   = out_free;
        rk_next    = RK_DONE;
        total_next = TOTAL_W'({packet_count, 7'd0});
        last_next  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_external         <= 1'b0;
      internal_base_address <= 32'd0;
      external_block        <= 7'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DEST_EXTERNAL:  dest_external         <= cfg_data[0];
        CFG_INTERNAL_BASE:  internal_base_address <= cfg_data;
        CFG_EXTERNAL_BLOCK: external_block        <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Control and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      session_active <= 1'b0;
      frame_length   <= 8'd0;
      first_byte     <= 8'd0;
      running_crc    <= 16'd0;
      received_crc   <= 16'd0;
      packet_count   <= '0;
      bit_cnt        <= 3'd0;
      word_idx       <= '0;
      result_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      if (item_fire && kind) begin
        session_active <= 1'b1;
        packet_count   <= '0;
        frame_length   <= 8'd0;
      end else if (is_byte) begin
        frame_length <= frame_end ? 8'd0 : len_new;
        if (frame_length == 8'd0) begin
          first_byte   <= rx_byte;
          running_crc  <= 16'd0;
          received_crc <= 16'd0;
        end
        if (is_payload) begin
          running_crc <= running_crc ^ {rx_byte, 8'd0};
          bit_cnt     <= 3'd0;
        end else if (frame_length == PAY_END) begin
          received_crc[15:8] <= rx_byte;
        end else if (frame_length == RCV_LO) begin
          received_crc[7:0] <= rx_byte;
        end
        if (frame_end && session_active) begin
          if (good_pkt) begin
            packet_count <= packet_count + 1'b1;
            word_idx     <= '0;
          end else if (is_eot) begin
            session_active <= 1'b0;
          end
        end
      end

      // Shared CRC unit: one polynomial step per cycle.
      if (state == S_CRC) begin
        running_crc <= running_crc[15] ? ({running_crc[14:0], 1'b0} ^ CRC_POLY)
                                       : {running_crc[14:0], 1'b0};
        bit_cnt     <= bit_cnt + 3'd1;
      end

      if (state == S_WORD && out_load) begin
        word_idx <= word_idx + 1'b1;
      end
    end
  end

  // Address of the current write word; the packet offset uses the old count.
  always_ff @(posedge clk) begin
    if (is_byte && frame_end && good_pkt) begin
      addr <= dest_base + {12'd0, packet_count, 7'd0};
    end else if (state == S_WORD && out_load) begin
      addr <= addr + 32'd8;
    end
  end

  // Payload bytes are gathered into a word and written once the word is full.
  always_ff @(posedge clk) begin
    if (is_byte && is_payload) begin
      word_buf <= {rx_byte, word_buf[63:8]};
      if (pay_off[2:0] == 3'd7) begin
        pkt_mem[pay_off[WORD_IDX_W+2:3]] <= {rx_byte, word_buf[63:8]};
      end
    end
    if (state == S_RD) begin
      rd_data <= pkt_mem[word_idx];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      result_kind   <= rk_next;
      reply_nak     <= nak_next;
      write_address <= addr_next;
      write_data    <= data_next;
      total_bytes   <= total_next;
      last          <= last_next;
    end
  end

  // Checks
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    item_fire && kind |=> session_active && packet_count == '0)
    else $error("start transfer did not open the session");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    packet_count <= COUNT_W'(MAX_PACKETS))
    else $error("packet count beyond its limit");

  a_write_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == RK_WRITE |-> !last)
    else $error("write word marked as last result");

  a_crc_bounded: assert property (@(posedge clk) disable iff (rst)
    state == S_CRC && bit_cnt == 3'd7 |=> state == S_IDLE)
    else $error("CRC sequence overran eight steps");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !result_valid || result_ready)
    else $error("result register overwritten before its transfer");

endmodule

[sim/tb_xmodem_crc_packet_receiver.sv]
`timescale 1ns / 1ps
// Self-checking bench for the XMODEM-CRC packet receiver: directed frames, good and damaged
// packets under one register setting, a good one under another, checked by a scoreboard predictor.
// Depends on xcpr_pkg and rtl/xmodem_crc_packet_receiver.sv.
module tb_xmodem_crc_packet_receiver;
  import xcpr_pkg::*;

  localparam logic        KIND_BYTE     = 1'b0;
  localparam logic        KIND_START    = 1'b1;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned IDLE_PERCENT  = 13;

  typedef logic [7:0] octet_q_t[$];

  typedef enum int {
    FAULT_NONE,
    FAULT_PAYLOAD,
    FAULT_CRC,
    FAULT_HEADER,
    FAULT_SHORT,
    FAULT_LONG
  } fault_t;

  typedef struct packed {
    logic [1:0]  res_kind;
    logic        nak;
    logic [31:0] addr;
    logic [63:0] data;
    logic [19:0] total;
    logic        fin;
  } xfer_result_t;

  class xmodem_scoreboard;
    bit             to_external;
    logic [31:0]    int_base;
    logic [6:0]     ext_block;
    bit             session_open;
    int unsigned    frame_len;
    logic [7:0]     lead;
    logic [15:0]    crc_acc;
    logic [15:0]    crc_rx;
    logic [63:0]    payload [WORDS];
    int unsigned    accepted;
    xfer_result_t   due[$];
    int unsigned    produced;
    int unsigned    errors;

    function new();
      to_external  = 1'b0;
      int_base     = '0;
      ext_block    = '0;
      session_open = 1'b0;
      frame_len    = 0;
      lead         = '0;
      crc_acc      = '0;
      crc_rx       = '0;
      accepted     = 0;
      produced     = 0;
      errors       = 0;
    endfunction

    static function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      int k;
      c = crc ^ {b, 8'h00};
      for (k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_DEST_EXTERNAL:  to_external = val[0];
        CFG_INTERNAL_BASE:  int_base = val;
        CFG_EXTERNAL_BLOCK: ext_block = val[6:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    function void add(logic [1:0] k, logic nak, logic [31:0] a, logic [63:0] d,
                      logic [19:0] t, logic fin);
      xfer_result_t r;
      r.res_kind = k;
      r.nak      = nak;
      r.addr     = a;
      r.data     = d;
      r.total    = t;
      r.fin      = fin;
      due.push_back(r);
      produced++;
    endfunction

    // Called for every accepted input transfer.
    function void note_item(bit opens, logic [7:0] b, logic fe);
      int unsigned pos;
      int unsigned i;
      logic [31:0] offset;
      logic [31:0] base;
      logic [31:0] total;
      if (opens) begin
        session_open = 1'b1;
        accepted     = 0;
        frame_len    = 0;
        return;
      end
      pos = frame_len;
      if (pos == 0) begin
        lead    = b;
        crc_acc = '0;
        crc_rx  = '0;
      end
      if (pos >= 3 && pos < 3 + PAYLOAD_BYTES) begin
        crc_acc = crc_update(crc_acc, b);
        payload[(pos - 3) / 8][((pos - 3) % 8) * 8 +: 8] = b;
      end else if (pos == 3 + PAYLOAD_BYTES) begin
        crc_rx[15:8] = b;
      end else if (pos == 4 + PAYLOAD_BYTES) begin
        crc_rx[7:0] = b;
      end
      if (frame_len < 255) frame_len++;
      if (!fe) return;
      if (session_open) begin
        if (frame_len == DATA_FRAME_LEN && lead == SOH) begin
          if (crc_acc == crc_rx && accepted < MAX_PACKETS) begin
            accepted++;
            offset = (accepted - 1) * PAYLOAD_BYTES;
            if (to_external) base = ({25'd0, ext_block} << 16) + offset;
            else base = int_base + offset;
            for (i = 0; i < WORDS; i++) add(RK_WRITE, 1'b0, base + 8 * i, payload[i], '0, 1'b0);
            add(RK_REPLY, 1'b0, '0, '0, '0, 1'b1);
          end else begin
            add(RK_REPLY, 1'b1, '0, '0, '0, 1'b1);
          end
        end else if (frame_len == 1 && lead == EOT) begin
          total = accepted * PAYLOAD_BYTES;
          add(RK_REPLY, 1'b0, '0, '0, '0, 1'b0);
          add(RK_DONE, 1'b0, '0, '0, total[19:0], 1'b1);
          session_open = 1'b0;
        end
      end
      frame_len = 0;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
      end
    endfunction

    function void check(xfer_result_t got);
      xfer_result_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind %0d addr %h data %h",
                 $time, got.res_kind, got.addr, got.data);
        return;
      end
      want = due.pop_front();
      compare_field("result_kind", want.res_kind, got.res_kind);
      compare_field("reply_nak", want.nak, got.nak);
      compare_field("write_address", want.addr, got.addr);
      compare_field("write_data", want.data, got.data);
      compare_field("total_bytes", want.total, got.total);
      compare_field("last", want.fin, got.fin);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic        kind = KIND_BYTE;
  logic [7:0]  rx_byte = '0;
  logic        frame_end = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [1:0]  result_kind;
  logic        reply_nak;
  logic [31:0] write_address;
  logic [63:0] write_data;
  logic [19:0] total_bytes;
  logic        last;

  xmodem_scoreboard sb;
  int unsigned      items_sent = 0;
  int unsigned      results_seen = 0;
  int unsigned      cycles = 0;

  xmodem_crc_packet_receiver i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .kind          (kind),
    .rx_byte       (rx_byte),
    .frame_end     (frame_end),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result_kind   (result_kind),
    .reply_nak     (reply_nak),
    .write_address (write_address),
    .write_data    (write_data),
    .total_bytes   (total_bytes),
    .last          (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      sb.check({result_kind, reply_nak, write_address, write_data, total_bytes, last});
      results_seen <= results_seen + 1;
    end
  end

  // Result side: random stalls, one long hold-off once a packet drain is under way,
  // and a calm window with no stalls at all.
  initial begin : sink
    int unsigned hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 10) begin
        held = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (results_seen >= 30 && results_seen < 60) begin
        result_ready <= 1'b1;
      end else begin
        result_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Entered and left at a falling edge; valid stays high across back-to-back transfers.
  task automatic send_item(input logic k, input logic [7:0] b, input logic fe);
    while ((items_sent < 200 || items_sent >= 330) && $urandom_range(0, 99) < IDLE_PERCENT) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    kind       <= k;
    rx_byte    <= b;
    frame_end  <= fe;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(k == KIND_START, b, fe);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input octet_q_t f, input bit close);
    int unsigned i;
    for (i = 0; i < f.size(); i++) send_item(KIND_BYTE, f[i], close && (i == f.size() - 1));
  endtask

  task automatic open_session();
    send_item(KIND_START, 8'($urandom()), 1'($urandom()));
  endtask

  task automatic program_regs(input bit dest, input logic [31:0] base, input logic [6:0] block);
    logic [31:0] dest_word;
    logic [31:0] block_word;
    // Spare upper bits carry noise; the block must ignore them.
    dest_word  = ($urandom() & ~32'h1) | {31'd0, dest};
    block_word = ($urandom() & ~32'h7F) | {25'd0, block};
    cfg_write <= 1'b1;
    cfg_index <= CFG_DEST_EXTERNAL;
    cfg_data  <= dest_word;
    @(negedge clk);
    cfg_index <= CFG_INTERNAL_BASE;
    cfg_data  <= base;
    @(negedge clk);
    cfg_index <= CFG_EXTERNAL_BLOCK;
    cfg_data  <= block_word;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(CFG_DEST_EXTERNAL, dest_word);
    sb.set_reg(CFG_INTERNAL_BASE, base);
    sb.set_reg(CFG_EXTERNAL_BLOCK, block_word);
  endtask

  // Waits until every predicted result has been taken, then lets the block finish
  // any byte that produces no result.
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic octet_q_t make_packet(fault_t fault);
    octet_q_t f;
    logic [15:0] crc;
    logic [7:0] fill;
    logic [7:0] num;
    int unsigned style;
    int unsigned i;
    int unsigned at;
    style = $urandom_range(0, 7);
    num = 8'($urandom());
    crc = '0;
    f.push_back(SOH);
    f.push_back(num);
    f.push_back(~num);
    for (i = 0; i < PAYLOAD_BYTES; i++) begin
      case (style)
        0: fill = 8'h00;
        1: fill = 8'hFF;
        default: fill = 8'($urandom());
      endcase
      crc = xmodem_scoreboard::crc_update(crc, fill);
      f.push_back(fill);
    end
    f.push_back(crc[15:8]);
    f.push_back(crc[7:0]);
    case (fault)
      FAULT_PAYLOAD: begin
        at = 3 + $urandom_range(0, PAYLOAD_BYTES - 1);
        f[at] = f[at] ^ 8'(1 << $urandom_range(0, 7));
      end
      FAULT_CRC: begin
        at = DATA_FRAME_LEN - 1 - $urandom_range(0, 1);
        f[at] = f[at] ^ 8'(1 << $urandom_range(0, 7));
      end
      FAULT_HEADER: f[0] = SOH ^ 8'($urandom_range(1, 255));
      FAULT_SHORT:  void'(f.pop_back());
      FAULT_LONG:   f.push_back(8'($urandom()));
      default: ;
    endcase
    return f;
  endfunction

  initial begin : stimulus
    octet_q_t f;
    sb = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    program_regs(1'b0, 32'hFFFF_FFC0, 7'($urandom()));

    // Frames before any session are tracked but answered with nothing.
    send_item(KIND_BYTE, EOT, 1'b1);
    send_item(KIND_BYTE, SOH, 1'b1);
    send_item(KIND_START, 8'hFF, 1'b1);
    send_item(KIND_BYTE, EOT, 1'b1);
    // The session is closed again, so a second end-of-transfer is ignored.
    send_item(KIND_BYTE, EOT, 1'b1);
    send_item(KIND_START, 8'h00, 1'b0);
    send_item(KIND_BYTE, EOT, 1'b0);
    send_item(KIND_BYTE, 8'h00, 1'b1);
    // A start item in the middle of a frame discards the bytes taken so far.
    send_item(KIND_BYTE, SOH, 1'b0);
    send_item(KIND_BYTE, 8'hFF, 1'b0);
    send_item(KIND_BYTE, 8'h00, 1'b0);
    send_item(KIND_BYTE, 8'h7E, 1'b0);
    send_item(KIND_START, 8'h5A, 1'b0);
    send_item(KIND_BYTE, EOT, 1'b1);
    send_item(KIND_START, 8'hA5, 1'b1);
    send_item(KIND_BYTE, 8'hFF, 1'b1);
    send_item(KIND_BYTE, 8'h00, 1'b1);

    // A good packet whose write addresses wrap past the top of the address space,
    // then one with a damaged check word, then the end of the transfer.
    send_frame(make_packet(FAULT_NONE), 1'b1);
    send_frame(make_packet(FAULT_CRC), 1'b1);
    f = {EOT};
    send_frame(f, 1'b1);

    drain();
    program_regs(1'b1, $urandom(), 7'd127);
    open_session();
    send_frame(make_packet(FAULT_NONE), 1'b1);
    send_frame(f, 1'b1);

    drain();
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
